[rtl/core/asm_comment_stripper_assert.svh]
// Assertion macros shared by the comment stripper RTL.
// Needs nothing else; assertions compile away when NO_ASSERTIONS is defined.
`ifndef ASM_COMMENT_STRIPPER_ASSERT_SVH
`define ASM_COMMENT_STRIPPER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked at every clock edge outside reset.
`define ACS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked at every clock edge, reset included.
`define ACS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ACS_ASSERT(label, clk, rst, prop, msg)
`define ACS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

[rtl/core/acs_pkg.sv]
// Package for the comment stripper: byte codes, line modes and the
// structs passed between its modules. Depends on nothing.
package acs_pkg;

   // Byte codes.
   localparam logic [7:0] LINE_FEED      = 8'h0A;
   localparam logic [7:0] EOF_BYTE       = 8'h1A;
   localparam logic [7:0] SPACE          = 8'h20;
   localparam logic [7:0] TAB            = 8'h09;
   localparam logic [7:0] CARRIAGE_RET   = 8'h0D;
   localparam logic [7:0] COMMENT_RESET  = 8'h3B;
   localparam logic [7:0] QUOTE_RESET    = 8'h27;

   // Register indexes of the control port.
   localparam logic [1:0] CSR_COMMENT = 2'd0;
   localparam logic [1:0] CSR_QUOTE   = 2'd1;

   // Line modes.
   localparam logic [1:0] MODE_SCAN   = 2'd0;
   localparam logic [1:0] MODE_STRIP  = 2'd1;
   localparam logic [1:0] MODE_INTACT = 2'd2;
   localparam logic [1:0] MODE_DROP   = 2'd3;

   // Port controls of the held-whitespace memory.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ram_ctl_type;

   // One output word.
   typedef struct packed {
      logic [7:0] char_out;
      logic       last_of_run;
   } out_word_type;

   // Space and the control whitespace codes except line feed.
   function automatic logic is_blank(input logic [7:0] c);
      logic r;
      r = (c == SPACE) || ((c >= TAB) && (c <= CARRIAGE_RET) && (c != LINE_FEED));
      return r;
   endfunction

endpackage

[rtl/core/acs_pend_ram.sv]
// Held-whitespace memory: one write port, one read port, registered read data.
// Depends on acs_pkg for the port control struct.
module acs_pend_ram #(
   parameter int DEPTH  = 63,
   parameter int ADDR_W = 6
) (
   input  logic                 clock,
   input  acs_pkg::ram_ctl_type ctl,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [7:0]           wr_data,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [7:0]           rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // A read at the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/acs_out_reg.sv]
// Output register of the result channel; takes a new word while the old one
// leaves. Depends on acs_pkg for the word struct.
module acs_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  acs_pkg::out_word_type push_word,
   output logic                  can_accept,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output acs_pkg::out_word_type word
);

   logic                  full_ff;
   logic                  full_in;
   acs_pkg::out_word_type word_ff;

   assign can_accept = !full_ff || rsp_ready;

   // The register stays full while a word is pushed or not yet taken.
   always_comb begin
      full_in = full_ff;
      if (push) begin
         full_in = 1'b1;
      end else if (rsp_ready) begin
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         word_ff <= push_word;
      end
   end

   assign rsp_valid = full_ff;
   assign word      = word_ff;

endmodule

[rtl/core/asm_comment_stripper.sv]
// Top level of the assembly comment stripper: line state machine, held
// whitespace queue pointers and config registers. Depends on acs_pkg,
// acs_pend_ram, acs_out_reg and asm_comment_stripper_assert.svh.
//
//   channel  | ports                              | direction
//   ---------+------------------------------------+----------
//   request  | req_valid/ready, char_in, eot      | in
//   response | rsp_valid/ready, char_out, last    | out
//   control  | csr_valid/ready, csr_index, data   | in
//
// A byte that gives one word or none is handled in the idle state.
// A byte that releases n held whitespace bytes goes through the flush state, one
// memory read per cycle while the output register can accept, then the closing byte.
// An overflowing whitespace byte waits in the overflow state on the registered memory read.
// Reset clears the line state and the queue; no clearing pass is needed.
// A stalled response channel holds the request channel off.
`include "asm_comment_stripper_assert.svh"

module asm_comment_stripper #(
   parameter int WS_DEPTH = 63
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_in,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_char_out,
   output logic       rsp_last_of_run,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   localparam int PTR_W = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;
   localparam int CNT_W = $clog2(WS_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FLUSH = 2'd1;
   localparam logic [1:0] ST_FINAL = 2'd2;
   localparam logic [1:0] ST_OVF   = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [1:0]       mode_ff, mode_in;
   logic             parity_ff, parity_in;
   logic             empty_ff, empty_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       final_ff, final_in;
   logic [7:0]       comment_ff, quote_ff;

   acs_pkg::ram_ctl_type  ram_ctl;
   logic [PTR_W-1:0]      ram_wr_addr;
   logic [PTR_W-1:0]      ram_rd_addr;
   logic [7:0]            ram_rd_data;
   logic                  push;
   acs_pkg::out_word_type push_word;
   acs_pkg::out_word_type out_word;
   logic                  out_can;

   logic             accept;
   logic [PTR_W-1:0] head_next;
   logic [SUM_W-1:0] tail_sum;
   logic [SUM_W-1:0] tail_wrap;
   logic [PTR_W-1:0] tail_ptr;

   // Control registers; writes beyond the list are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         comment_ff <= acs_pkg::COMMENT_RESET;
         quote_ff   <= acs_pkg::QUOTE_RESET;
      end else if (csr_valid) begin
         if (csr_index == acs_pkg::CSR_COMMENT) begin
            comment_ff <= csr_data;
         end else if (csr_index == acs_pkg::CSR_QUOTE) begin
            quote_ff <= csr_data;
         end
      end
   end

   // Queue pointer arithmetic, circular over the whitespace memory.
   assign head_next = (head_ff == PTR_W'(WS_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail_wrap = (tail_sum >= SUM_W'(WS_DEPTH)) ? tail_sum - SUM_W'(WS_DEPTH) : tail_sum;
   assign tail_ptr  = tail_wrap[PTR_W-1:0];

   assign req_ready = (state_ff == ST_IDLE) && out_can;
   assign accept    = req_valid && req_ready;

   // Line state machine; held bytes are read one per cycle from the memory while the output register can accept.
   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      parity_in   = parity_ff;
      empty_in    = empty_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      final_in    = final_ff;
      ram_ctl     = '0;
      ram_wr_addr = tail_ptr;
      ram_rd_addr = head_ff;
      push        = 1'b0;
      push_word.char_out    = ram_rd_data;
      push_word.last_of_run = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_end_of_text || (req_char_in == acs_pkg::LINE_FEED)) begin
                  // End of line or text: flush while scanning, then close.
                  final_in  = req_end_of_text ? acs_pkg::EOF_BYTE : acs_pkg::LINE_FEED;
                  mode_in   = acs_pkg::MODE_SCAN;
                  parity_in = 1'b0;
                  empty_in  = 1'b1;
                  if ((mode_ff == acs_pkg::MODE_SCAN) && (count_ff != '0)) begin
                     ram_ctl.rd_en = 1'b1;
                     head_in       = head_next;
                     count_in      = count_ff - 1'b1;
                     state_in      = ST_FLUSH;
                  end else begin
                     count_in = '0;
                     if (req_end_of_text || (mode_ff == acs_pkg::MODE_SCAN)
                         || (mode_ff == acs_pkg::MODE_INTACT)) begin
                        push = 1'b1;
                        push_word.char_out    = final_in;
                        push_word.last_of_run = 1'b1;
                     end
                  end
               end else if (mode_ff == acs_pkg::MODE_INTACT) begin
                  push = 1'b1;
                  push_word.char_out    = req_char_in;
                  push_word.last_of_run = 1'b1;
               end else if (mode_ff != acs_pkg::MODE_SCAN) begin
                  // Rest of a stripped or dropped line is discarded.
               end else if (req_char_in == comment_ff) begin
                  empty_in = 1'b0;
                  if (empty_ff) begin
                     mode_in  = acs_pkg::MODE_DROP;
                     count_in = '0;
                  end else if (parity_ff) begin
                     mode_in  = acs_pkg::MODE_INTACT;
                     final_in = req_char_in;
                     if (count_ff != '0) begin
                        ram_ctl.rd_en = 1'b1;
                        head_in       = head_next;
                        count_in      = count_ff - 1'b1;
                        state_in      = ST_FLUSH;
                     end else begin
                        push = 1'b1;
                        push_word.char_out    = req_char_in;
                        push_word.last_of_run = 1'b1;
                     end
                  end else begin
                     mode_in  = acs_pkg::MODE_STRIP;
                     count_in = '0;
                     push     = 1'b1;
                     push_word.char_out    = acs_pkg::LINE_FEED;
                     push_word.last_of_run = 1'b1;
                  end
               end else begin
                  empty_in = 1'b0;
                  if (req_char_in == quote_ff) begin
                     parity_in = !parity_ff;
                  end
                  if (acs_pkg::is_blank(req_char_in)) begin
                     ram_ctl.wr_en = 1'b1;
                     if (count_ff >= CNT_W'(WS_DEPTH)) begin
                        // Full queue: the oldest byte leaves, the new one
                        // takes its slot, which is the tail as well.
                        ram_ctl.rd_en = 1'b1;
                        ram_wr_addr   = head_ff;
                        head_in       = head_next;
                        state_in      = ST_OVF;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end else begin
                     final_in = req_char_in;
                     if (count_ff != '0) begin
                        ram_ctl.rd_en = 1'b1;
                        head_in       = head_next;
                        count_in      = count_ff - 1'b1;
                        state_in      = ST_FLUSH;
                     end else begin
                        push = 1'b1;
                        push_word.char_out    = req_char_in;
                        push_word.last_of_run = 1'b1;
                     end
                  end
               end
            end
         end
         ST_FLUSH: begin
            // Send the byte just read and fetch the next one.
            if (out_can) begin
               push = 1'b1;
               if (count_ff != '0) begin
                  ram_ctl.rd_en = 1'b1;
                  head_in       = head_next;
                  count_in      = count_ff - 1'b1;
               end else begin
                  state_in = ST_FINAL;
               end
            end
         end
         ST_FINAL: begin
            if (out_can) begin
               push = 1'b1;
               push_word.char_out    = final_ff;
               push_word.last_of_run = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_OVF: begin
            if (out_can) begin
               push = 1'b1;
               push_word.last_of_run = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         mode_ff   <= acs_pkg::MODE_SCAN;
         parity_ff <= 1'b0;
         empty_ff  <= 1'b1;
         head_ff   <= '0;
         count_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         parity_ff <= parity_in;
         empty_ff  <= empty_in;
         head_ff   <= head_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      final_ff <= final_in;
   end

   acs_pend_ram #(
      .DEPTH  (WS_DEPTH),
      .ADDR_W (PTR_W)
   ) u_pend_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .wr_addr (ram_wr_addr),
      .wr_data (req_char_in),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   acs_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_word  (push_word),
      .can_accept (out_can),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .word       (out_word)
   );

   assign rsp_char_out    = out_word.char_out;
   assign rsp_last_of_run = out_word.last_of_run;

   // Checks on the queue and the sequencer.
   `ACS_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(WS_DEPTH), "queue count overrun")
   `ACS_ASSERT(a_head_bound, clock, reset, head_ff <= PTR_W'(WS_DEPTH - 1), "head out of range")
   `ACS_ASSERT(a_no_hold_off_scan, clock, reset, ((state_ff == ST_IDLE) && (mode_ff != acs_pkg::MODE_SCAN)) |-> (count_ff == '0), "whitespace held outside scanning")
   `ACS_ASSERT(a_ovf_full, clock, reset, (state_ff == ST_OVF) |-> (count_ff == CNT_W'(WS_DEPTH)), "overflow with queue not full")
   `ACS_ASSERT(a_push_room, clock, reset, push |-> out_can, "word pushed into a full output register")

endmodule
